[rtl/dual_stack_shared_memory_core_defines.svh]
// Assertion macros shared by the dual stack core modules.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef DUAL_STACK_SHARED_MEMORY_CORE_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define DSSM_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("dssm assertion failed");

// Antecedent implies consequent in the same cycle
`define DSSM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dssm assertion failed");

// Antecedent implies consequent in the next cycle
`define DSSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dssm assertion failed");

`endif

[rtl/dssm_pkg.sv]
// Package for the dual stack core: operation and status codes, item structs.
// No dependencies; imported by dssm_ctrl, the top level and the testbench.
`timescale 1ns / 1ps

package dssm_pkg;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// Request item
	typedef struct packed {
		logic [1:0]         operation;
		logic               which_stack;
		logic signed [31:0] push_value;
	} req_item_t;

	// Response item
	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [3:0]         top_index;
		logic               lower_empty;
		logic               lower_full;
		logic               upper_empty;
		logic               upper_full;
	} rsp_item_t;

	// Everything of a response except the element read back
	typedef struct packed {
		logic       rd_ok;
		status_t    status;
		logic [3:0] top_index;
		logic       lower_empty;
		logic       lower_full;
		logic       upper_empty;
		logic       upper_full;
	} meta_t;

endpackage

[rtl/dssm_mem.sv]
// Element store of the dual stack core: one synchronous single-port RAM.
// Read data is registered and held until the next read.
`timescale 1ns / 1ps

module dssm_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on push, capture read data on pop or peek
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/dssm_ctrl.sv]
// Pointer control of the dual stack core: decode, bounds checks, pointer update.
// Depends on dssm_pkg; drives the element store port and the response metadata.
`timescale 1ns / 1ps
`include "dual_stack_shared_memory_core_defines.svh"

module dssm_ctrl
	import dssm_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  req_item_t        item,
	output logic             mem_we,
	output logic             mem_re,
	output logic [AW-1:0]    mem_addr,
	output logic [WIDTH-1:0] mem_wdata,
	output meta_t            meta
);

	localparam logic [AW-1:0] LowerBase = AW'(1 + (DEPTH - 1) / 2);
	localparam logic [AW-1:0] UpperBase = AW'((DEPTH - 1) / 2);
	localparam logic [AW-1:0] UpperLast = AW'(DEPTH - 1);

	logic [AW-1:0]    lower_q, upper_q;
	logic [AW-1:0]    lower_d, upper_d;
	logic [AW-1:0]    ptr_sel, top_sel;
	logic             empty_sel, full_sel;
	logic             rd_ok;
	status_t          status;
	logic [AW+3:0]    top_ext;
	logic [WIDTH+31:0] push_ext;

	// Current top and bounds of the selected stack
	assign ptr_sel   = item.which_stack ? upper_q : lower_q;
	assign empty_sel = item.which_stack ? (upper_q == UpperBase) : (lower_q == LowerBase);
	assign full_sel  = item.which_stack ? (upper_q == UpperLast) : (lower_q == '0);

	// Sign-extend the pushed value, then cut it to the element width
	assign push_ext  = {{WIDTH{item.push_value[31]}}, item.push_value};
	assign mem_wdata = push_ext[WIDTH-1:0];

	// Decode the operation
	always_comb begin
		lower_d  = lower_q;
		upper_d  = upper_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = ptr_sel;
		status   = ST_OK;
		rd_ok    = 1'b0;
		unique case (item.operation) inside
			OP_PUSH: begin
				if (full_sel) begin
					status = ST_OVERFLOW;
				end else begin
					mem_we = accept;
					if (item.which_stack) begin
						upper_d  = upper_q + AW'(1);
						mem_addr = upper_q + AW'(1);
					end else begin
						lower_d  = lower_q - AW'(1);
						mem_addr = lower_q - AW'(1);
					end
				end
			end
			OP_POP, OP_PEEK: begin
				if (empty_sel) begin
					status = ST_UNDERFLOW;
				end else begin
					mem_re = accept;
					rd_ok  = 1'b1;
					if (item.operation == OP_POP) begin
						if (item.which_stack) begin
							upper_d = upper_q - AW'(1);
						end else begin
							lower_d = lower_q + AW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Hold pointers, advance them on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LowerBase;
			upper_q <= UpperBase;
		end else if (accept) begin
			lower_q <= lower_d;
			upper_q <= upper_d;
		end
	end

	// Response metadata from the pointers after the item
	assign top_sel = item.which_stack ? upper_d : lower_d;
	assign top_ext = {4'b0000, top_sel};

	always_comb begin
		meta.rd_ok       = rd_ok;
		meta.status      = status;
		meta.top_index   = top_ext[3:0];
		meta.lower_empty = (lower_d == LowerBase);
		meta.lower_full  = (lower_d == '0);
		meta.upper_empty = (upper_d == UpperBase);
		meta.upper_full  = (upper_d == UpperLast);
	end

	`DSSM_ASSERT_ALWAYS(a_lower_in_range, lower_q <= LowerBase)
	`DSSM_ASSERT_ALWAYS(a_upper_in_range, upper_q >= UpperBase)
	`DSSM_ASSERT_ALWAYS(a_one_access, !(mem_we && mem_re))
	`DSSM_ASSERT_SAME(a_error_no_access, accept && (status != ST_OK), !mem_we && !mem_re)

endmodule

[rtl/dual_stack_shared_memory_core.sv]
// Top level of the dual stack core: handshake, read stage and response register.
// Depends on dssm_pkg, dssm_ctrl and dssm_mem.
//
//  channel | signals                   | payload
//  --------+---------------------------+-----------
//  request | req_valid, req_ready      | req (req_item_t)
//  response| rsp_valid, rsp_ready      | rsp (rsp_item_t)
//
// One item per cycle while responses are taken; an accepted request passes
// the read stage, beside the registered read port of the element store, then the response register.
// Reset puts both pointers at their bases; the element store is not cleared.
// A stalled response holds one item in the read stage, then drops req_ready.
`timescale 1ns / 1ps
`include "dual_stack_shared_memory_core_defines.svh"

module dual_stack_shared_memory_core
	import dssm_pkg::*;
#(
	parameter int STACK_DEPTH   = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int AW = $clog2(STACK_DEPTH);

	logic                     accept, advance;
	logic                     mem_we, mem_re;
	logic [AW-1:0]            mem_addr;
	logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;
	meta_t                    meta;
	logic                     valid_s1;
	meta_t                    meta_s1;
	logic                     rsp_valid_q;
	rsp_item_t                rsp_q;
	logic [ELEMENT_WIDTH+31:0] rd_ext;

	// Handshake
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	dssm_ctrl #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (ELEMENT_WIDTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (req),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.meta      (meta)
	);

	dssm_mem #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (ELEMENT_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Read stage: hold the metadata while the store read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// Sign-extend the element read back, then cut it to 32 bits
	assign rd_ext = {{32{mem_rdata[ELEMENT_WIDTH-1]}}, mem_rdata};

	// Response register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_value  <= meta_s1.rd_ok ? rd_ext[31:0] : 32'sd0;
			rsp_q.status      <= meta_s1.status;
			rsp_q.top_index   <= meta_s1.top_index;
			rsp_q.lower_empty <= meta_s1.lower_empty;
			rsp_q.lower_full  <= meta_s1.lower_full;
			rsp_q.upper_empty <= meta_s1.upper_empty;
			rsp_q.upper_full  <= meta_s1.upper_full;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DSSM_ASSERT_SAME(a_stall_blocks_req, valid_s1 && rsp_valid_q && !rsp_ready, !req_ready)
	`DSSM_ASSERT_NEXT(a_accept_fills_s1, accept, valid_s1)
	`DSSM_ASSERT_NEXT(a_rsp_drains, rsp_valid_q && rsp_ready && !valid_s1, !rsp_valid_q)

endmodule

[tb/sv/dual_stack_shared_memory_core_tb.sv]
// Self-checking testbench for dual_stack_shared_memory_core: push, pop and peek on both
// stacks, compared item by item against a predictor of the two stacks.
// Depends on dssm_pkg and the core RTL only.
`timescale 1ns / 1ps

module dual_stack_shared_memory_core_tb;
	import dssm_pkg::*;

	localparam int DEPTH        = 16;
	localparam int LOWER_BASE   = 1 + (DEPTH - 1) / 2;
	localparam int UPPER_BASE   = (DEPTH - 1) / 2;
	localparam int UPPER_LAST   = DEPTH - 1;
	localparam int RANDOM_ITEMS = 1030;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	// Operation code with no meaning; the core must ignore it
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// Stack selection
	localparam logic STACK_LOWER = 1'b0;
	localparam logic STACK_UPPER = 1'b1;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	dual_stack_shared_memory_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	req_item_t pending_requests[$];
	rsp_item_t expected_responses[$];
	int        mismatch_count = 0;
	int        cycle_count    = 0;
	logic      req_fired      = 1'b0;

	// Predicted state of the shared store and both top pointers
	logic signed [31:0] element_store [DEPTH];
	int                 lower_top = LOWER_BASE;
	int                 upper_top = UPPER_BASE;

	// Sender burst and gap counters, receiver stall pattern
	int burst_left  = 1;
	int gap_left    = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one item to the predicted stacks and return the response it should give
	function automatic rsp_item_t stack_outcome(req_item_t item);
		rsp_item_t res;
		res = '0;
		res.status = ST_OK;
		case (item.operation)
			OP_PUSH: begin
				if (item.which_stack == STACK_UPPER) begin
					if (upper_top == UPPER_LAST)
						res.status = ST_OVERFLOW;
					else begin
						upper_top++;
						element_store[upper_top] = item.push_value;
					end
				end else begin
					if (lower_top == 0)
						res.status = ST_OVERFLOW;
					else begin
						lower_top--;
						element_store[lower_top] = item.push_value;
					end
				end
			end
			OP_POP, OP_PEEK: begin
				if (item.which_stack == STACK_UPPER) begin
					if (upper_top == UPPER_BASE)
						res.status = ST_UNDERFLOW;
					else begin
						res.read_value = element_store[upper_top];
						if (item.operation == OP_POP)
							upper_top--;
					end
				end else begin
					if (lower_top == LOWER_BASE)
						res.status = ST_UNDERFLOW;
					else begin
						res.read_value = element_store[lower_top];
						if (item.operation == OP_POP)
							lower_top++;
					end
				end
			end
			default: ;
		endcase
		res.top_index   = (item.which_stack == STACK_UPPER) ? upper_top[3:0] : lower_top[3:0];
		res.lower_empty = (lower_top == LOWER_BASE);
		res.lower_full  = (lower_top == 0);
		res.upper_empty = (upper_top == UPPER_BASE);
		res.upper_full  = (upper_top == UPPER_LAST);
		return res;
	endfunction

	function automatic req_item_t make_request(logic [1:0] op, logic stk, logic signed [31:0] value);
		req_item_t item;
		item.operation   = op;
		item.which_stack = stk;
		item.push_value  = value;
		return item;
	endfunction

	function automatic logic signed [31:0] random_element();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return -32'sd1;
			3:       return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	// Compare every field of one response with its prediction
	task automatic check_response(rsp_item_t exp_rsp, rsp_item_t got);
		if (got.read_value !== exp_rsp.read_value) begin
			$error("read_value: expected %0d, got %0d", exp_rsp.read_value, got.read_value);
			mismatch_count++;
		end
		if (got.status !== exp_rsp.status) begin
			$error("status: expected %0d, got %0d", exp_rsp.status, got.status);
			mismatch_count++;
		end
		if (got.top_index !== exp_rsp.top_index) begin
			$error("top_index: expected %0d, got %0d", exp_rsp.top_index, got.top_index);
			mismatch_count++;
		end
		if (got.lower_empty !== exp_rsp.lower_empty) begin
			$error("lower_empty: expected %0b, got %0b", exp_rsp.lower_empty, got.lower_empty);
			mismatch_count++;
		end
		if (got.lower_full !== exp_rsp.lower_full) begin
			$error("lower_full: expected %0b, got %0b", exp_rsp.lower_full, got.lower_full);
			mismatch_count++;
		end
		if (got.upper_empty !== exp_rsp.upper_empty) begin
			$error("upper_empty: expected %0b, got %0b", exp_rsp.upper_empty, got.upper_empty);
			mismatch_count++;
		end
		if (got.upper_full !== exp_rsp.upper_full) begin
			$error("upper_full: expected %0b, got %0b", exp_rsp.upper_full, got.upper_full);
			mismatch_count++;
		end
	endtask

	// Monitor: check each taken response, then predict each accepted item
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_responses.size() == 0) begin
					$error("unexpected response item: read_value %0d status %0d",
						rsp.read_value, rsp.status);
					mismatch_count++;
				end else
					check_response(expected_responses.pop_front(), rsp);
			end
			if (req_valid && req_ready)
				expected_responses.push_back(stack_outcome(req));
			req_fired <= req_valid && req_ready;
		end
	end

	// Give up if the run hangs
	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Driver: hold an unaccepted item, otherwise send in bursts separated by gaps
	always @(negedge clk) begin
		if (arst_n && !(req_valid && !req_fired)) begin
			if (gap_left != 0) begin
				req_valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (pending_requests.size() != 0) begin
				req       <= pending_requests.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 32);
					case ($urandom_range(0, 7))
						0, 1, 2: gap_left <= 0;
						7:       gap_left <= $urandom_range(10, 20);
						default: gap_left <= $urandom_range(1, 6);
					endcase
				end else
					burst_left <= burst_left - 1;
			end else
				req_valid <= 1'b0;
		end
	end

	// Receiver: stall on its own pattern of segments
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(10, 60);
			rsp_ready  <= 1'b1;
		end else begin
			stall_left <= stall_left - 1;
			case (stall_mode)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= 1'($urandom_range(0, 1));
				2:       rsp_ready <= ($urandom_range(0, 4) == 0);
				default: rsp_ready <= ($urandom_range(0, 11) == 0) ? 1'b1 : 1'b0;
			endcase
		end
	end

	// Build the stimulus, release reset, then wait for the core to drain
	initial begin
		int       sent;
		int       run_len;
		int       run_kind;
		int       pick;
		logic     run_stack;
		logic     stk;
		logic [1:0] op;

		// Underflow on both empty stacks and an ignored code
		pending_requests.push_back(make_request(OP_POP, STACK_LOWER, 32'sd0));
		pending_requests.push_back(make_request(OP_PEEK, STACK_UPPER, 32'sd0));
		pending_requests.push_back(make_request(OP_RESERVED, STACK_LOWER, 32'sh1234_5678));
		// Fill the lower stack to index zero, then overflow it
		pending_requests.push_back(make_request(OP_PUSH, STACK_LOWER, 32'sh7fff_ffff));
		pending_requests.push_back(make_request(OP_PUSH, STACK_LOWER, 32'sh8000_0000));
		pending_requests.push_back(make_request(OP_PUSH, STACK_LOWER, -32'sd1));
		pending_requests.push_back(make_request(OP_PUSH, STACK_LOWER, 32'sd0));
		for (int i = 0; i < 4; i++)
			pending_requests.push_back(make_request(OP_PUSH, STACK_LOWER, $urandom));
		pending_requests.push_back(make_request(OP_PUSH, STACK_LOWER, 32'sh5555_5555));
		pending_requests.push_back(make_request(OP_PEEK, STACK_LOWER, 32'sd0));
		pending_requests.push_back(make_request(OP_POP, STACK_LOWER, 32'sd0));
		// Upper stack: push, peek, drain and underflow
		pending_requests.push_back(make_request(OP_PUSH, STACK_UPPER, 32'sh8000_0000));
		pending_requests.push_back(make_request(OP_PUSH, STACK_UPPER, 32'sh7fff_ffff));
		pending_requests.push_back(make_request(OP_PEEK, STACK_UPPER, 32'sd0));
		pending_requests.push_back(make_request(OP_POP, STACK_UPPER, 32'sd0));
		pending_requests.push_back(make_request(OP_POP, STACK_UPPER, 32'sd0));
		pending_requests.push_back(make_request(OP_POP, STACK_UPPER, 32'sd0));

		// Random runs: fill and drain one stack to reach full and empty, plus noise
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			run_len   = $urandom_range(4, 24);
			run_kind  = $urandom_range(0, 4);
			run_stack = 1'($urandom_range(0, 1));
			for (int i = 0; i < run_len; i++) begin
				pick = $urandom_range(0, 99);
				stk  = ($urandom_range(0, 9) == 0 || run_kind == 4) ?
					1'($urandom_range(0, 1)) : run_stack;
				case (run_kind)
					0, 1:    op = (pick < 75) ? OP_PUSH : (pick < 88) ? OP_PEEK : OP_POP;
					2:       op = (pick < 70) ? OP_POP : (pick < 85) ? OP_PEEK : OP_PUSH;
					3:       op = (pick < 34) ? OP_PUSH : (pick < 67) ? OP_POP : OP_PEEK;
					default: op = 2'($urandom_range(0, 3));
				endcase
				pending_requests.push_back(make_request(op, stk, random_element()));
				if (op != OP_RESERVED)
					sent++;
			end
		end

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/dssm_pkg.sv
rtl/dssm_mem.sv
rtl/dssm_ctrl.sv
rtl/dual_stack_shared_memory_core.sv
tb/sv/dual_stack_shared_memory_core_tb.sv
